### src/vlrc_pkg.sv
// ----------------------------------------------------------------------------
// vlrc_pkg
// Shared constants, types and the rule program of the lighting controller.
// ----------------------------------------------------------------------------
package vlrc_pkg;

    localparam int STACK_DEPTH = 5;
    localparam int NUM_LAMPS   = 4;
    localparam int ENTRY_DEPTH = NUM_LAMPS * STACK_DEPTH;
    localparam int ENTRY_AW    = $clog2(ENTRY_DEPTH);
    localparam int FILL_W      = $clog2(STACK_DEPTH + 1);
    localparam int ENTRY_W     = 3;
    localparam int HOLD_W      = 20;
    localparam int SAMPLE_W    = 10;
    localparam int CFG_IDX_W   = 1;
    localparam int NUM_OPS     = 20;
    localparam int OP_PC_W     = $clog2(NUM_OPS);

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX   = '1;
    localparam logic [HOLD_W-1:0]   HOLD_RESET   = 20'd60000;
    localparam logic [SAMPLE_W-1:0] SAMPLE_RESET = 10'd50;

    localparam logic [CFG_IDX_W-1:0] CFG_HOLD   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE = 1'd1;

    localparam logic [1:0] LAMP_HEAD = 2'd0;
    localparam logic [1:0] LAMP_DAY  = 2'd1;
    localparam logic [1:0] LAMP_DOME = 2'd2;
    localparam logic [1:0] LAMP_FOOT = 2'd3;

    localparam logic [1:0] TAG_IGN    = 2'd0;
    localparam logic [1:0] TAG_DOOR   = 2'd1;
    localparam logic [1:0] TAG_LOCK   = 2'd2;
    localparam logic [1:0] TAG_UNLOCK = 2'd3;

    localparam logic [NUM_OPS-1:0] MASK_IGN_RISE    = 20'h00003;
    localparam logic [NUM_OPS-1:0] MASK_IGN_FALL    = 20'h0003C;
    localparam logic [NUM_OPS-1:0] MASK_DOOR_RISE   = 20'h00040;
    localparam logic [NUM_OPS-1:0] MASK_DOOR_FALL   = 20'h00080;
    localparam logic [NUM_OPS-1:0] MASK_LOCK_RISE   = 20'h00700;
    localparam logic [NUM_OPS-1:0] MASK_UNLOCK_RISE = 20'h01800;
    localparam logic [NUM_OPS-1:0] MASK_CHECKS      = 20'h22000;
    localparam logic [NUM_OPS-1:0] MASK_LOCK_EXP    = 20'h1C000;
    localparam logic [NUM_OPS-1:0] MASK_UNLOCK_EXP  = 20'hC0000;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUSH,
        OP_PUSH_DARK,
        OP_REMOVE,
        OP_LOCK_ARM,
        OP_UNLOCK_ARM,
        OP_LOCK_CHECK,
        OP_UNLOCK_CHECK
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic [1:0] lamp;
        logic [1:0] tag;
        logic       on;
    } op_t;

    function automatic op_t op_at(input logic [OP_PC_W-1:0] pc);
        op_t op;
        op = '{kind: OP_NONE, lamp: LAMP_HEAD, tag: TAG_IGN, on: 1'b0};
        case (pc)
            5'd0:  op = '{OP_PUSH,         LAMP_DAY,  TAG_IGN,    1'b1};
            5'd1:  op = '{OP_PUSH,         LAMP_FOOT, TAG_IGN,    1'b1};
            5'd2:  op = '{OP_REMOVE,       LAMP_DAY,  TAG_IGN,    1'b0};
            5'd3:  op = '{OP_REMOVE,       LAMP_FOOT, TAG_IGN,    1'b0};
            5'd4:  op = '{OP_PUSH,         LAMP_DOME, TAG_IGN,    1'b1};
            5'd5:  op = '{OP_PUSH,         LAMP_DAY,  TAG_IGN,    1'b1};
            5'd6:  op = '{OP_PUSH_DARK,    LAMP_DOME, TAG_DOOR,   1'b1};
            5'd7:  op = '{OP_PUSH,         LAMP_DOME, TAG_DOOR,   1'b0};
            5'd8:  op = '{OP_LOCK_ARM,     LAMP_DOME, TAG_LOCK,   1'b0};
            5'd9:  op = '{OP_PUSH,         LAMP_DAY,  TAG_LOCK,   1'b0};
            5'd10: op = '{OP_PUSH,         LAMP_HEAD, TAG_LOCK,   1'b1};
            5'd11: op = '{OP_UNLOCK_ARM,   LAMP_HEAD, TAG_UNLOCK, 1'b1};
            5'd12: op = '{OP_PUSH,         LAMP_DOME, TAG_UNLOCK, 1'b1};
            5'd13: op = '{OP_LOCK_CHECK,   LAMP_HEAD, TAG_LOCK,   1'b0};
            5'd14: op = '{OP_REMOVE,       LAMP_HEAD, TAG_LOCK,   1'b0};
            5'd15: op = '{OP_REMOVE,       LAMP_DOME, TAG_LOCK,   1'b0};
            5'd16: op = '{OP_REMOVE,       LAMP_DAY,  TAG_LOCK,   1'b0};
            5'd17: op = '{OP_UNLOCK_CHECK, LAMP_HEAD, TAG_UNLOCK, 1'b0};
            5'd18: op = '{OP_REMOVE,       LAMP_HEAD, TAG_UNLOCK, 1'b0};
            5'd19: op = '{OP_REMOVE,       LAMP_DOME, TAG_UNLOCK, 1'b0};
            default: op = '{OP_NONE,       LAMP_HEAD, TAG_IGN,    1'b0};
        endcase
        return op;
    endfunction

    function automatic logic [ENTRY_AW-1:0] lamp_addr(input logic [1:0] lamp,
                                                      input logic [FILL_W-1:0] idx);
        logic [ENTRY_AW-1:0] base;
        base = ENTRY_AW'(ENTRY_AW'(lamp) * ENTRY_AW'(STACK_DEPTH));
        return base + ENTRY_AW'(idx);
    endfunction

endpackage

### src/vlrc_ram.sv
// ----------------------------------------------------------------------------
// vlrc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vlrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/vehicle_lighting_rule_controller.sv
// ----------------------------------------------------------------------------
// vehicle_lighting_rule_controller
// Debounced switch sampling, rule sequencer over four tagged lamp stacks held
// in one RAM, and lock/unlock hold timers.
//
// channel | dir | handshake        | payload
// s       | in  | s_tvalid/tready  | s_tdata: switch levels
// m       | out | m_tvalid/tready  | m_tdata: lamp drives, hold flags
// cfg     | in  | cfg_wr_en        | cfg_index, cfg_data
//
// A tick reads each entry scanned by a tag removal, moves the top entry into
// each matching slot, and reads the dome top on a door opening; the sequencer
// walks a fixed 20-step rule program and then reads the four stack tops, all
// through the single RAM read port.
// Reset clears fills and timers and resets the sampling state; the RAM needs no clear.
// A finished word waits in the output register while the next tick is taken.
// ----------------------------------------------------------------------------
module vehicle_lighting_rule_controller (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // ignition_on, door_open, lock_request, unlock_request
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // headlight, day_light, dome_light, footwell_light,
                                  // lock_hold_running, unlock_hold_running
    input  logic                                 cfg_wr_en,
    input  logic [vlrc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [vlrc_pkg::HOLD_W-1:0]          cfg_data
);

    import vlrc_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_OP       = 8'b0000_0010,
        ST_REM_CHK  = 8'b0000_0100,
        ST_REM_MOV  = 8'b0000_1000,
        ST_DARK_CHK = 8'b0001_0000,
        ST_OUT_RD   = 8'b0010_0000,
        ST_OUT_CAP  = 8'b0100_0000,
        ST_DONE     = 8'b1000_0000
    } state_t;

    state_t               state_reg, state_next;
    logic [OP_PC_W-1:0]   pc_reg, pc_next;
    logic [NUM_OPS-1:0]   en_reg, en_next;
    logic [FILL_W-1:0]    idx_reg, idx_next;
    logic [1:0]           k_reg, k_next;
    logic [FILL_W-1:0]    fill_reg [NUM_LAMPS];
    logic [FILL_W-1:0]    fill_next [NUM_LAMPS];
    logic [3:0]           prev_reg, prev_next;
    logic [SAMPLE_W-1:0]  tss_reg, tss_next;
    logic                 lock_act_reg, lock_act_next;
    logic                 unlock_act_reg, unlock_act_next;
    logic                 lock_started_reg, lock_started_next;
    logic                 unlock_started_reg, unlock_started_next;
    logic [HOLD_W-1:0]    lock_el_reg, lock_el_next;
    logic [HOLD_W-1:0]    unlock_el_reg, unlock_el_next;
    logic [HOLD_W-1:0]    hold_reg, hold_next;
    logic [SAMPLE_W-1:0]  sample_reg, sample_next;
    logic [3:0]           tops_reg, tops_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [7:0]           m_tdata_reg, m_tdata_next;

    logic                 ram_we;
    logic [ENTRY_AW-1:0]  ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic                 ram_re;
    logic [ENTRY_AW-1:0]  ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;

    op_t                  op;
    logic [1:0]           cur_lamp;
    logic [FILL_W-1:0]    cur_fill;
    logic                 push_blocked;
    logic                 last_op;
    logic                 advance;
    logic                 do_push;
    logic                 accept;
    logic [SAMPLE_W-1:0]  tss_inc;
    logic                 due;
    logic [3:0]           lv;
    logic [3:0]           rise;
    logic [3:0]           fall;

    vlrc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRY_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign op       = op_at(pc_reg);
    assign cur_lamp = (state_reg == ST_OUT_RD || state_reg == ST_OUT_CAP) ? k_reg : op.lamp;
    assign cur_fill = fill_reg[cur_lamp];
    assign last_op  = (pc_reg == OP_PC_W'(NUM_OPS - 1));
    assign push_blocked = (lock_act_reg && op.tag == TAG_IGN &&
                           (op.lamp == LAMP_DAY || op.lamp == LAMP_DOME)) ||
                          (cur_fill >= FILL_W'(STACK_DEPTH));

    assign tss_inc = (tss_reg == SAMPLE_MAX) ? tss_reg : tss_reg + 1'b1;
    assign due     = (tss_inc >= sample_reg);
    assign lv      = s_tdata[3:0];
    assign rise    = lv & ~prev_reg;
    assign fall    = ~lv & prev_reg;

    always_comb
    begin
        state_next          = state_reg;
        pc_next             = pc_reg;
        en_next             = en_reg;
        idx_next            = idx_reg;
        k_next              = k_reg;
        fill_next           = fill_reg;
        prev_next           = prev_reg;
        tss_next            = tss_reg;
        lock_act_next       = lock_act_reg;
        unlock_act_next     = unlock_act_reg;
        lock_started_next   = lock_started_reg;
        unlock_started_next = unlock_started_reg;
        lock_el_next        = lock_el_reg;
        unlock_el_next      = unlock_el_reg;
        hold_next           = hold_reg;
        sample_next         = sample_reg;
        tops_next           = tops_reg;
        m_tvalid_next       = m_tvalid_reg;
        m_tdata_next        = m_tdata_reg;
        ram_we              = 1'b0;
        ram_waddr           = lamp_addr(cur_lamp, cur_fill);
        ram_wdata           = {op.tag, op.on};
        ram_re              = 1'b0;
        ram_raddr           = lamp_addr(cur_lamp, idx_reg);
        advance             = 1'b0;
        do_push             = 1'b0;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_HOLD:   hold_next   = cfg_data;
                CFG_SAMPLE: sample_next = cfg_data[SAMPLE_W-1:0];
                default:    hold_next   = hold_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pc_next             = '0;
                    idx_next            = '0;
                    lock_started_next   = 1'b0;
                    unlock_started_next = 1'b0;
                    en_next             = MASK_CHECKS;
                    state_next          = ST_OP;
                    if (due)
                    begin
                        tss_next  = '0;
                        prev_next = lv;
                        en_next   = MASK_CHECKS
                                  | (rise[0] ? MASK_IGN_RISE    : '0)
                                  | (fall[0] ? MASK_IGN_FALL    : '0)
                                  | (rise[1] ? MASK_DOOR_RISE   : '0)
                                  | (fall[1] ? MASK_DOOR_FALL   : '0)
                                  | (rise[2] ? MASK_LOCK_RISE   : '0)
                                  | (rise[3] ? MASK_UNLOCK_RISE : '0);
                    end
                    else
                    begin
                        tss_next = tss_inc;
                    end
                end
            end
            ST_OP:
            begin
                if (!en_reg[pc_reg])
                begin
                    advance = 1'b1;
                end
                else
                begin
                    case (op.kind)
                        OP_PUSH:
                        begin
                            do_push = 1'b1;
                            advance = 1'b1;
                        end
                        OP_PUSH_DARK:
                        begin
                            if (cur_fill == '0)
                            begin
                                do_push = 1'b1;
                                advance = 1'b1;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = lamp_addr(cur_lamp, cur_fill - 1'b1);
                                state_next = ST_DARK_CHK;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (idx_reg < cur_fill)
                            begin
                                ram_re     = 1'b1;
                                state_next = ST_REM_CHK;
                            end
                            else
                            begin
                                advance = 1'b1;
                            end
                        end
                        OP_LOCK_ARM:
                        begin
                            lock_act_next     = 1'b1;
                            lock_el_next      = '0;
                            lock_started_next = 1'b1;
                            do_push           = 1'b1;
                            advance           = 1'b1;
                        end
                        OP_UNLOCK_ARM:
                        begin
                            unlock_act_next     = 1'b1;
                            unlock_el_next      = '0;
                            unlock_started_next = 1'b1;
                            do_push             = 1'b1;
                            advance             = 1'b1;
                        end
                        OP_LOCK_CHECK:
                        begin
                            if (lock_act_reg && !lock_started_reg)
                            begin
                                if (lock_el_reg >= hold_reg)
                                begin
                                    en_next       = en_reg | MASK_LOCK_EXP;
                                    lock_act_next = 1'b0;
                                end
                                else
                                begin
                                    lock_el_next = lock_el_reg + 1'b1;
                                end
                            end
                            advance = 1'b1;
                        end
                        OP_UNLOCK_CHECK:
                        begin
                            if (unlock_act_reg && !unlock_started_reg)
                            begin
                                if (unlock_el_reg >= hold_reg)
                                begin
                                    en_next         = en_reg | MASK_UNLOCK_EXP;
                                    unlock_act_next = 1'b0;
                                end
                                else
                                begin
                                    unlock_el_next = unlock_el_reg + 1'b1;
                                end
                            end
                            advance = 1'b1;
                        end
                        default:
                        begin
                            advance = 1'b1;
                        end
                    endcase
                end
            end
            ST_DARK_CHK:
            begin
                do_push = !ram_rdata[0];
                advance = 1'b1;
            end
            ST_REM_CHK:
            begin
                if (ram_rdata[2:1] == op.tag)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = lamp_addr(cur_lamp, cur_fill - 1'b1);
                    state_next = ST_REM_MOV;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_OP;
                end
            end
            ST_REM_MOV:
            begin
                ram_we              = 1'b1;
                ram_waddr           = lamp_addr(cur_lamp, idx_reg);
                ram_wdata           = ram_rdata;
                fill_next[cur_lamp] = cur_fill - 1'b1;
                state_next          = ST_OP;
            end
            ST_OUT_RD:
            begin
                ram_re     = (cur_fill != '0);
                ram_raddr  = lamp_addr(cur_lamp, cur_fill - 1'b1);
                state_next = ST_OUT_CAP;
            end
            ST_OUT_CAP:
            begin
                tops_next[k_reg] = (cur_fill != '0) && ram_rdata[0];
                k_next           = k_reg + 1'b1;
                state_next       = (k_reg == 2'd3) ? ST_DONE : ST_OUT_RD;
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, unlock_act_reg, lock_act_reg, tops_reg};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (do_push && !push_blocked)
        begin
            ram_we              = 1'b1;
            ram_waddr           = lamp_addr(cur_lamp, cur_fill);
            ram_wdata           = {op.tag, op.on};
            fill_next[cur_lamp] = cur_fill + 1'b1;
        end

        if (advance)
        begin
            idx_next = '0;
            pc_next  = pc_reg + 1'b1;
            if (last_op)
            begin
                k_next     = '0;
                state_next = ST_OUT_RD;
            end
            else
            begin
                state_next = ST_OP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            pc_reg             <= '0;
            en_reg             <= '0;
            idx_reg            <= '0;
            k_reg              <= '0;
            for (int i = 0; i < NUM_LAMPS; i++)
            begin
                fill_reg[i] <= '0;
            end
            prev_reg           <= '0;
            tss_reg            <= SAMPLE_MAX;
            lock_act_reg       <= 1'b0;
            unlock_act_reg     <= 1'b0;
            lock_started_reg   <= 1'b0;
            unlock_started_reg <= 1'b0;
            lock_el_reg        <= '0;
            unlock_el_reg      <= '0;
            hold_reg           <= HOLD_RESET;
            sample_reg         <= SAMPLE_RESET;
            m_tvalid_reg       <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            pc_reg             <= pc_next;
            en_reg             <= en_next;
            idx_reg            <= idx_next;
            k_reg              <= k_next;
            fill_reg           <= fill_next;
            prev_reg           <= prev_next;
            tss_reg            <= tss_next;
            lock_act_reg       <= lock_act_next;
            unlock_act_reg     <= unlock_act_next;
            lock_started_reg   <= lock_started_next;
            unlock_started_reg <= unlock_started_next;
            lock_el_reg        <= lock_el_next;
            unlock_el_reg      <= unlock_el_next;
            hold_reg           <= hold_next;
            sample_reg         <= sample_next;
            m_tvalid_reg       <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tops_reg    <= tops_next;
        m_tdata_reg <= m_tdata_next;
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg[0] <= FILL_W'(STACK_DEPTH) && fill_reg[1] <= FILL_W'(STACK_DEPTH) &&
        fill_reg[2] <= FILL_W'(STACK_DEPTH) && fill_reg[3] <= FILL_W'(STACK_DEPTH))
        else $error("lamp stack fill beyond depth");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a tick is in work");

    a_word_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("output word raised outside the done step");

    a_lock_started_active: assert property (@(posedge clk) disable iff (!rst_n)
        lock_started_reg |-> lock_act_reg)
        else $error("lock timer marked started but idle");

    a_unlock_started_active: assert property (@(posedge clk) disable iff (!rst_n)
        unlock_started_reg |-> unlock_act_reg)
        else $error("unlock timer marked started but idle");
`endif

endmodule
